// ----- rtl/cbq_pkg.sv -----
// Shared types and constants for the two-section Q15 biquad filter.
// Used by the multiplier unit, the top level and the testbench.
// No dependencies.
package cbq_pkg;

    // Coefficient format: signed Q15 halves of 32-bit registers.
    localparam int CoefWidth    = 16;
    localparam int QShift       = 15;
    localparam int CfgDataWidth = 32;
    localparam int CfgIdxWidth  = 3;
    localparam int StepWidth    = 4;

    typedef logic signed [CoefWidth-1:0] t_coef;
    typedef logic [CfgIdxWidth-1:0]      t_cfg_idx;
    typedef logic [CfgDataWidth-1:0]     t_cfg_word;
    typedef logic [StepWidth-1:0]        t_step;

    // Configuration register indexes.
    localparam t_cfg_idx REG_GAIN = 3'd0;
    localparam t_cfg_idx REG_B1   = 3'd1;
    localparam t_cfg_idx REG_B2   = 3'd2;
    localparam t_cfg_idx REG_A1   = 3'd3;
    localparam t_cfg_idx REG_A2   = 3'd4;

    // Configuration reset values.
    localparam t_cfg_word GAIN_RESET = 32'h5E14_3487;
    localparam t_cfg_word B1_RESET   = 32'hAA71_BAF4;
    localparam t_cfg_word B2_RESET   = 32'h4000_7FFC;
    localparam t_cfg_word A1_RESET   = 32'h79D4_55F6;
    localparam t_cfg_word A2_RESET   = 32'hC7C5_8758;

    // Multiply steps issued to the shared multiplier, in issue order.
    localparam t_step STEP_GB11 = 4'd0;
    localparam t_step STEP_GB21 = 4'd1;
    localparam t_step STEP_GB12 = 4'd2;
    localparam t_step STEP_GB22 = 4'd3;
    localparam t_step STEP_W_A1 = 4'd4;
    localparam t_step STEP_W_A2 = 4'd5;
    localparam t_step STEP_W_X0 = 4'd6;
    localparam t_step STEP_W_X1 = 4'd7;
    localparam t_step STEP_W_X2 = 4'd8;
    localparam t_step STEP_Y_A1 = 4'd9;
    localparam t_step STEP_Y_A2 = 4'd10;
    localparam t_step STEP_Y_W0 = 4'd11;
    localparam t_step STEP_Y_W1 = 4'd12;
    localparam t_step STEP_Y_W2 = 4'd13;
    // Last count: the final product is accumulated, nothing is issued.
    localparam t_step STEP_END  = 4'd14;

endpackage

// ----- rtl/cbq_mul.sv -----
// Shared Q15 multiplier: signed coefficient times signed data, registered,
// then an arithmetic shift right by 15 (floor) and a wrap to the data width.
// Depends on cbq_pkg.
module cbq_mul #(
    parameter int DATA_WIDTH = 16
) (
    input  logic                         i_clk,
    input  logic                         i_en,
    input  cbq_pkg::t_coef               i_coef,
    input  logic signed [DATA_WIDTH-1:0] i_data,
    output logic signed [DATA_WIDTH-1:0] o_prod
);
    import cbq_pkg::*;

    localparam int ProdWidth = CoefWidth + DATA_WIDTH;

    logic signed [ProdWidth-1:0] full_prod;
    logic signed [ProdWidth-1:0] r_prod;

    // Full-width signed product.
    assign full_prod = ProdWidth'(i_coef) * ProdWidth'(i_data);

    // Product register; holds when no step is issued.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= full_prod;
        end
    end

    // Dropping the low 15 bits of a two's complement value is a floor shift.
    assign o_prod = r_prod[QShift +: DATA_WIDTH];

endmodule

// ----- rtl/cascaded_biquad_iir_q15.sv -----
// Two cascaded direct-form-I biquad sections in Q15, one shared multiplier.
// A sample is taken in ST_IDLE; ST_RUN runs the 14 products through the
// registered multiplier and accumulates them, and ST_DONE publishes the result
// once the output register is free. No new sample is accepted before ST_IDLE.
// Reset (i_rst_n, synchronous, active low) clears all histories and the output
// valid, and restores the coefficient registers to their default values.
module cascaded_biquad_iir_q15 #(
    parameter int SAMPLE_WIDTH = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // Configuration write port
    input  logic                i_cfg_we,
    input  cbq_pkg::t_cfg_idx   i_cfg_idx,
    input  cbq_pkg::t_cfg_word  i_cfg_data,
    // Input sample channel
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic signed [15:0]  i_sample_in,
    // Output sample channel
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic signed [15:0]  o_sample_out
);
    import cbq_pkg::*;

    localparam int SW = SAMPLE_WIDTH;
    // Multiplier data operand must carry both samples and coefficients.
    localparam int DW = (SAMPLE_WIDTH > CoefWidth) ? SAMPLE_WIDTH : CoefWidth;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DONE
    } t_state;

    // Control, configuration and history registers
    t_state                r_state, n_state;
    t_step                 r_cnt, n_cnt;
    logic                  r_out_valid, n_out_valid;
    logic signed [15:0]    r_out, n_out;
    t_cfg_word             r_gain, n_gain;
    t_cfg_word             r_b1, n_b1;
    t_cfg_word             r_b2, n_b2;
    t_cfg_word             r_a1, n_a1;
    t_cfg_word             r_a2, n_a2;
    logic signed [SW-1:0]  r_x1, n_x1;
    logic signed [SW-1:0]  r_x2, n_x2;
    logic signed [SW-1:0]  r_w1, n_w1;
    logic signed [SW-1:0]  r_w2, n_w2;
    logic signed [SW-1:0]  r_y1, n_y1;
    logic signed [SW-1:0]  r_y2, n_y2;

    // Datapath registers
    logic signed [SW-1:0]  r_x, n_x;
    logic signed [SW-1:0]  r_w, n_w;
    logic signed [SW-1:0]  r_y, n_y;
    t_coef                 r_gb11, n_gb11;
    t_coef                 r_gb21, n_gb21;
    t_coef                 r_gb12, n_gb12;
    t_coef                 r_gb22, n_gb22;

    // Coefficient halves
    t_coef g1, g2, b11, b12, b21, b22, a11, a12, a21, a22;
    t_coef b12_dbl, b22_dbl, a11_dbl;

    // Shared multiplier signals
    logic                  mul_en;
    t_coef                 mul_coef;
    logic signed [DW-1:0]  mul_data;
    logic signed [DW-1:0]  mul_prod;
    logic signed [SW-1:0]  prod_s;
    t_coef                 prod_c;
    t_step                 acc_step;
    logic                  in_xfer;
    logic                  out_xfer;
    logic                  out_free;

    assign g1  = r_gain[15:0];
    assign g2  = r_gain[31:16];
    assign b11 = r_b1[15:0];
    assign b12 = r_b1[31:16];
    assign b21 = r_b2[15:0];
    assign b22 = r_b2[31:16];
    assign a11 = r_a1[15:0];
    assign a12 = r_a1[31:16];
    assign a21 = r_a2[15:0];
    assign a22 = r_a2[31:16];

    // Doubled coefficients wrap to 16 bits.
    assign b12_dbl = {b12[CoefWidth-2:0], 1'b0};
    assign b22_dbl = {b22[CoefWidth-2:0], 1'b0};
    assign a11_dbl = {a11[CoefWidth-2:0], 1'b0};

    // Handshakes
    assign o_in_stall   = (r_state != ST_IDLE);
    assign in_xfer      = i_in_valid && !o_in_stall;
    assign o_out_valid  = r_out_valid;
    assign o_sample_out = r_out;
    assign out_xfer     = r_out_valid && !i_out_stall;
    assign out_free     = !r_out_valid || !i_out_stall;

    // Operand selection for the step issued this cycle.
    assign mul_en = (r_state == ST_RUN) && (r_cnt != STEP_END);
    always_comb begin
        mul_coef = '0;
        mul_data = '0;
        case (r_cnt)
            STEP_GB11: begin mul_coef = g1;      mul_data = DW'(b11);     end
            STEP_GB21: begin mul_coef = g1;      mul_data = DW'(b21);     end
            STEP_GB12: begin mul_coef = g2;      mul_data = DW'(b12_dbl); end
            STEP_GB22: begin mul_coef = g2;      mul_data = DW'(b22_dbl); end
            STEP_W_A1: begin mul_coef = a11_dbl; mul_data = DW'(r_w1);    end
            STEP_W_A2: begin mul_coef = a21;     mul_data = DW'(r_w2);    end
            STEP_W_X0: begin mul_coef = g1;      mul_data = DW'(r_x);     end
            STEP_W_X1: begin mul_coef = r_gb11;  mul_data = DW'(r_x1);    end
            STEP_W_X2: begin mul_coef = r_gb21;  mul_data = DW'(r_x2);    end
            STEP_Y_A1: begin mul_coef = a12;     mul_data = DW'(r_y1);    end
            STEP_Y_A2: begin mul_coef = a22;     mul_data = DW'(r_y2);    end
            STEP_Y_W0: begin mul_coef = g2;      mul_data = DW'(r_w);     end
            STEP_Y_W1: begin mul_coef = r_gb12;  mul_data = DW'(r_w1);    end
            STEP_Y_W2: begin mul_coef = r_gb22;  mul_data = DW'(r_w2);    end
            default:   begin mul_coef = '0;      mul_data = '0;           end
        endcase
    end

    cbq_mul #(
        .DATA_WIDTH (DW)
    ) u_mul (
        .i_clk  (i_clk),
        .i_en   (mul_en),
        .i_coef (mul_coef),
        .i_data (mul_data),
        .o_prod (mul_prod)
    );

    // The product in the multiplier register belongs to the previous step.
    assign prod_s   = mul_prod[SW-1:0];
    assign prod_c   = mul_prod[CoefWidth-1:0];
    assign acc_step = r_cnt - t_step'(1);

    // Next-state logic for sequencer, configuration, histories and datapath.
    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        n_gain      = r_gain;
        n_b1        = r_b1;
        n_b2        = r_b2;
        n_a1        = r_a1;
        n_a2        = r_a2;
        n_x1        = r_x1;
        n_x2        = r_x2;
        n_w1        = r_w1;
        n_w2        = r_w2;
        n_y1        = r_y1;
        n_y2        = r_y2;
        n_x         = r_x;
        n_w         = r_w;
        n_y         = r_y;
        n_gb11      = r_gb11;
        n_gb21      = r_gb21;
        n_gb12      = r_gb12;
        n_gb22      = r_gb22;

        // Register writes; unknown indexes are ignored.
        if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_GAIN: n_gain = i_cfg_data;
                REG_B1:   n_b1   = i_cfg_data;
                REG_B2:   n_b2   = i_cfg_data;
                REG_A1:   n_a1   = i_cfg_data;
                REG_A2:   n_a2   = i_cfg_data;
                default:  ;
            endcase
        end

        // The output register empties on its transfer.
        if (out_xfer) begin
            n_out_valid = 1'b0;
        end

        // Accumulate the product of the previous step.
        if (r_state == ST_RUN && r_cnt != STEP_GB11) begin
            case (acc_step)
                STEP_GB11: n_gb11 = prod_c;
                STEP_GB21: n_gb21 = prod_c;
                STEP_GB12: n_gb12 = prod_c;
                STEP_GB22: n_gb22 = prod_c;
                STEP_W_A1: n_w    = prod_s;
                STEP_W_A2, STEP_W_X0, STEP_W_X1, STEP_W_X2:
                    n_w = r_w + prod_s;
                STEP_Y_A1: n_y    = prod_s;
                STEP_Y_A2, STEP_Y_W0, STEP_Y_W1, STEP_Y_W2:
                    n_y = r_y + prod_s;
                default: ;
            endcase
        end

        // Sequencer
        case (r_state)
            ST_IDLE: begin
                if (in_xfer) begin
                    n_x     = SW'(i_sample_in);
                    n_cnt   = STEP_GB11;
                    n_state = ST_RUN;
                end
            end
            ST_RUN: begin
                if (r_cnt == STEP_END) begin
                    n_state = ST_DONE;
                end else begin
                    n_cnt = r_cnt + t_step'(1);
                end
            end
            ST_DONE: begin
                // Publish the result and shift every history once.
                if (out_free) begin
                    n_out       = 16'(r_y);
                    n_out_valid = 1'b1;
                    n_x2        = r_x1;
                    n_x1        = r_x;
                    n_w2        = r_w1;
                    n_w1        = r_w;
                    n_y2        = r_y1;
                    n_y1        = r_y;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // State, configuration, histories and registered outputs.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= STEP_GB11;
            r_out_valid <= 1'b0;
            r_out       <= '0;
            r_gain      <= GAIN_RESET;
            r_b1        <= B1_RESET;
            r_b2        <= B2_RESET;
            r_a1        <= A1_RESET;
            r_a2        <= A2_RESET;
            r_x1        <= '0;
            r_x2        <= '0;
            r_w1        <= '0;
            r_w2        <= '0;
            r_y1        <= '0;
            r_y2        <= '0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
            r_out       <= n_out;
            r_gain      <= n_gain;
            r_b1        <= n_b1;
            r_b2        <= n_b2;
            r_a1        <= n_a1;
            r_a2        <= n_a2;
            r_x1        <= n_x1;
            r_x2        <= n_x2;
            r_w1        <= n_w1;
            r_w2        <= n_w2;
            r_y1        <= n_y1;
            r_y2        <= n_y2;
        end
    end

    // Working registers of the current sample.
    always_ff @(posedge i_clk) begin
        r_x    <= n_x;
        r_w    <= n_w;
        r_y    <= n_y;
        r_gb11 <= n_gb11;
        r_gb21 <= n_gb21;
        r_gb12 <= n_gb12;
        r_gb22 <= n_gb22;
    end

endmodule

// ----- rtl/cbq_chk.sv -----
// Port-level checker for the two-section Q15 biquad filter, and its binding.
// Depends on cascaded_biquad_iir_q15 for the bind target.
module cbq_chk (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_stall,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input logic signed [15:0] o_sample_out
);

    // Reset empties the output register.
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    // A stalled result stays offered unchanged.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_sample_out))
        else $error("stalled result dropped or changed");

    // After an input transfer the block is busy with that sample.
    a_busy_after_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input taken while a sample is in work");

    // A new result cannot appear right after the input transfer.
    a_no_instant_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> !$rose(o_out_valid))
        else $error("result appeared one cycle after input");

    // The block does not finish a sample too early.
    a_busy_two: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> ##1 o_in_stall)
        else $error("sample finished too early");

endmodule

bind cascaded_biquad_iir_q15 cbq_chk u_cbq_chk (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in_valid),
    .o_in_stall   (o_in_stall),
    .o_out_valid  (o_out_valid),
    .i_out_stall  (i_out_stall),
    .o_sample_out (o_sample_out)
);

// ----- tb/tb_top.sv -----
// Self-checking testbench for the two-section Q15 biquad filter cascaded_biquad_iir_q15.
// Drives samples and coefficient writes, predicts every filtered sample and compares.
// Depends on rtl/cbq_pkg.sv and rtl/cascaded_biquad_iir_q15.sv.
module tb_top;
    import cbq_pkg::*;

    localparam int CLK_HALF       = 6;
    localparam int RESET_CYCLES   = 8;
    localparam int LATENCY        = 16;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int RANDOM_PHASES  = 8;
    localparam int PHASE_ITEMS    = 125;

    // Clock, reset and stimulus signals, all known from time zero.
    logic      i_clk        = 1'b0;
    logic      i_rst_n      = 1'b0;
    logic      i_cfg_we     = 1'b0;
    t_cfg_idx  i_cfg_idx    = REG_GAIN;
    t_cfg_word i_cfg_data   = '0;
    logic      i_in_valid   = 1'b0;
    t_coef     i_sample_in  = '0;
    logic      i_out_stall  = 1'b0;
    logic      o_in_stall;
    logic      o_out_valid;
    t_coef     o_sample_out;

    // Samples waiting for the driver, and filtered samples waiting for the DUT.
    t_coef samples_to_send[$];
    t_coef filtered_due[$];

    int unsigned samples_queued  = 0;
    int unsigned outputs_checked = 0;
    int unsigned errors          = 0;
    int unsigned idle_cycles     = 0;
    int unsigned send_gap        = 0;
    int unsigned stall_left      = 0;
    logic        in_taken        = 1'b0;
    logic        no_idle         = 1'b0;

    // Predictor copy of the coefficient registers and the filter histories.
    t_cfg_word gain_word = GAIN_RESET;
    t_cfg_word b1_word   = B1_RESET;
    t_cfg_word b2_word   = B2_RESET;
    t_cfg_word a1_word   = A1_RESET;
    t_cfg_word a2_word   = A2_RESET;
    t_coef in_d1  = '0, in_d2  = '0;
    t_coef mid_d1 = '0, mid_d2 = '0;
    t_coef out_d1 = '0, out_d2 = '0;

    always #CLK_HALF i_clk = ~i_clk;

    cascaded_biquad_iir_q15 #(
        .SAMPLE_WIDTH(16)
    ) DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_sample_in (i_sample_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_sample_out(o_sample_out)
    );

    // Q15 multiply: the arithmetic shift floors, and bits 30:15 wrap to 16 bits.
    function automatic t_coef q15_product(t_coef coef, t_coef data);
        logic signed [31:0] full;
        full = coef * data;
        return full[30:15];
    endfunction

    // A doubled coefficient wraps to 16 bits.
    function automatic t_coef doubled(t_coef coef);
        return t_coef'({coef[14:0], 1'b0});
    endfunction

    // One sample through both sections; every history then moves by one.
    function automatic t_coef biquad_cascade_step(t_coef x);
        t_coef g1, g2, b11, b12, b21, b22, a11, a12, a21, a22;
        t_coef gb11, gb21, gb12, gb22, w, y;
        g1  = gain_word[15:0];
        g2  = gain_word[31:16];
        b11 = b1_word[15:0];
        b12 = b1_word[31:16];
        b21 = b2_word[15:0];
        b22 = b2_word[31:16];
        a11 = a1_word[15:0];
        a12 = a1_word[31:16];
        a21 = a2_word[15:0];
        a22 = a2_word[31:16];
        gb11 = q15_product(g1, b11);
        gb21 = q15_product(g1, b21);
        gb12 = q15_product(g2, doubled(b12));
        gb22 = q15_product(g2, doubled(b22));
        w = q15_product(doubled(a11), mid_d1) + q15_product(a21, mid_d2)
            + q15_product(g1, x) + q15_product(gb11, in_d1) + q15_product(gb21, in_d2);
        y = q15_product(a12, out_d1) + q15_product(a22, out_d2)
            + q15_product(g2, w) + q15_product(gb12, mid_d1) + q15_product(gb22, mid_d2);
        in_d2  = in_d1;
        in_d1  = x;
        mid_d2 = mid_d1;
        mid_d1 = w;
        out_d2 = out_d1;
        out_d1 = y;
        return y;
    endfunction

    // Idle lengths: mostly none or short, now and then long.
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Samples: mostly full range, some extremes and some small values.
    function automatic t_coef pick_sample();
        int unsigned r;
        r = $urandom_range(0, 9);
        case (r)
            0: begin
                case ($urandom_range(0, 4))
                    0: return 16'sh7FFF;
                    1: return 16'sh8000;
                    2: return 16'sh0000;
                    3: return 16'shFFFF;
                    default: return 16'sh0001;
                endcase
            end
            1: return t_coef'($signed($urandom_range(0, 255)) - 128);
            default: return t_coef'($urandom());
        endcase
    endfunction

    // Coefficient halves: random half of the time, the Q15 extremes otherwise.
    function automatic logic [15:0] pick_half();
        case ($urandom_range(0, 7))
            0: return 16'h7FFF;
            1: return 16'h8000;
            2: return 16'h0000;
            3: return 16'hFFFF;
            default: return 16'($urandom());
        endcase
    endfunction

    task automatic queue_sample(input t_coef x);
        samples_to_send.push_back(x);
        samples_queued++;
    endtask

    // Block until every queued sample has come back through the output.
    task automatic drain();
        while (outputs_checked != samples_queued) @(negedge i_clk);
    endtask

    // Write all five registers, then one random index past the last register.
    task automatic program_filter(input t_cfg_word g, b1, b2, a1, a2);
        t_cfg_word words[5];
        t_cfg_idx  idxs[5];
        words = '{g, b1, b2, a1, a2};
        idxs  = '{REG_GAIN, REG_B1, REG_B2, REG_A1, REG_A2};
        for (int k = 0; k < 5; k++) begin
            @(negedge i_clk);
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= idxs[k];
            i_cfg_data <= words[k];
        end
        // An out-of-range index must leave every coefficient unchanged.
        @(negedge i_clk);
        i_cfg_idx  <= t_cfg_idx'($urandom_range(REG_A2 + 1, (1 << CfgIdxWidth) - 1));
        i_cfg_data <= $urandom();
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    // Sample driver: holds a stalled transfer, otherwise waits out its gap and sends.
    always @(negedge i_clk) begin : drive_samples
        logic  next_valid;
        t_coef next_sample;
        next_valid  = i_in_valid;
        next_sample = i_sample_in;
        if (i_rst_n) begin
            if (i_in_valid && in_taken) next_valid = 1'b0;
            if (!next_valid) begin
                if (send_gap > 0) begin
                    send_gap--;
                end else if (samples_to_send.size() > 0) begin
                    next_sample = samples_to_send.pop_front();
                    next_valid  = 1'b1;
                    send_gap    = pick_gap();
                end
            end
        end
        i_in_valid  <= next_valid;
        i_sample_in <= next_sample;
    end

    // Output back-pressure: random stall bursts, none while idling is off.
    always @(negedge i_clk) begin : drive_stall
        logic next_stall;
        next_stall = 1'b0;
        if (stall_left > 0) begin
            stall_left--;
            next_stall = 1'b1;
        end else if (!no_idle && $urandom_range(0, 3) == 0) begin
            stall_left = pick_gap();
        end
        i_out_stall <= next_stall;
    end

    // Monitor: mirrors register writes, predicts on each input transfer and
    // checks each output transfer against the oldest prediction.
    always @(posedge i_clk) begin : monitor
        t_coef want;
        logic  active;
        active = 1'b0;
        if (i_rst_n) begin
            if (i_cfg_we) begin
                active = 1'b1;
                case (i_cfg_idx)
                    REG_GAIN: gain_word = i_cfg_data;
                    REG_B1:   b1_word   = i_cfg_data;
                    REG_B2:   b2_word   = i_cfg_data;
                    REG_A1:   a1_word   = i_cfg_data;
                    REG_A2:   a2_word   = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_in_valid && !o_in_stall) begin
                active = 1'b1;
                filtered_due.push_back(biquad_cascade_step(i_sample_in));
            end
            if (o_out_valid && !i_out_stall) begin
                active = 1'b1;
                if (filtered_due.size() == 0) begin
                    errors++;
                    $error("sample_out: no sample expected, actual %0d", o_sample_out);
                end else begin
                    want = filtered_due.pop_front();
                    outputs_checked++;
                    if (o_sample_out !== want) begin
                        errors++;
                        $error("sample_out mismatch: expected %0d, actual %0d",
                               want, o_sample_out);
                    end
                end
            end
            // Watchdog on cycles without any transfer.
            idle_cycles = active ? 0 : idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("cascaded_biquad_iir_q15 regression: fail");
                $finish;
            end
        end
        in_taken <= i_rst_n && i_in_valid && !o_in_stall;
    end

    // Test sequence: reset, directed phases, then random phases.
    initial begin
        t_cfg_word extremes[4];
        extremes = '{32'h7FFF_7FFF, 32'h8000_8000, 32'h0000_0000, 32'hFFFF_FFFF};

        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset coefficients: impulses, extremes and alternating bit patterns.
        queue_sample(16'sh7FFF);
        queue_sample(16'sh0000);
        queue_sample(16'sh0000);
        queue_sample(16'sh0000);
        queue_sample(16'sh8000);
        queue_sample(16'sh0000);
        queue_sample(16'sh0000);
        queue_sample(16'shFFFF);
        queue_sample(16'sh0001);
        queue_sample(16'sh5555);
        queue_sample(16'shAAAA);
        queue_sample(16'sh3039);
        drain();

        // Every register at each extreme; wrapping products and sums.
        foreach (extremes[e]) begin
            program_filter(extremes[e], extremes[e], extremes[e], extremes[e], extremes[e]);
            queue_sample(16'sh7FFF);
            queue_sample(16'sh8000);
            if (e != 2) begin
                queue_sample(16'sh8000);
                queue_sample(e[0] ? 16'shFFFF : 16'sh0001);
            end
            drain();
        end

        // Random coefficients per phase; one phase runs without idling.
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            no_idle = (p == 4);
            program_filter({pick_half(), pick_half()}, {pick_half(), pick_half()},
                           {pick_half(), pick_half()}, {pick_half(), pick_half()},
                           {pick_half(), pick_half()});
            repeat (PHASE_ITEMS) queue_sample(pick_sample());
            drain();
        end
        no_idle = 1'b0;

        // Let any stray output show up before the verdict.
        repeat (LATENCY + 8) @(negedge i_clk);
        if (filtered_due.size() != 0) begin
            errors++;
            $error("sample_out: %0d expected samples never arrived", filtered_due.size());
        end
        if (errors == 0) begin
            $display("cascaded_biquad_iir_q15 regression: pass");
        end else begin
            $display("cascaded_biquad_iir_q15 regression: fail");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/cbq_pkg.sv
rtl/cbq_mul.sv
rtl/cascaded_biquad_iir_q15.sv
rtl/cbq_chk.sv
tb/tb_top.sv
